### hw/rtl/lru_handle_pool_macros.svh
// ----------------------------------------------------------------------------
// lru handle pool assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LRU_HANDLE_POOL_MACROS_SVH
`define LRU_HANDLE_POOL_MACROS_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define LHP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// checked at every edge, reset included
`define LHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define LHP_ASSERT(lbl, clk, rst_n, prop, msg)
`define LHP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hw/rtl/lhp_pkg.sv
// ----------------------------------------------------------------------------
// lhp_pkg
// shared constants, request codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package lhp_pkg;

    localparam int SLOT_W     = 8;
    localparam int OP_W       = 3;
    localparam int OWNER_W    = 16;
    localparam int USABLE_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [SLOT_W-1:0] NONE_SLOT = 8'hFF;

    // request codes
    localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
    localparam logic [OP_W-1:0] OP_TOUCH = 3'd2;
    localparam logic [OP_W-1:0] OP_CHECK = 3'd3;
    localparam logic [OP_W-1:0] OP_INVAL = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCRATCH_SLOT = 1'b1;

    // register reset values
    localparam logic [USABLE_W-1:0] USABLE_COUNT_RST = 7'd64;
    localparam logic [SLOT_W-1:0]   SCRATCH_SLOT_RST = 8'd15;

    // controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic latch_cfg;
        logic sweep_init;
        logic sweep_clear;
        logic init_fix;
        logic rd_issue;
        logic link1;
        logic link2;
        logic link3;
        logic wr_owner;
        logic set_grant;
        logic set_match;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic slot_ok;
        logic sweep_last;
    } t_stat;

endpackage

`default_nettype wire

### hw/rtl/lhp_ctrl.sv
// ----------------------------------------------------------------------------
// lhp_ctrl
// request sequencer: sweeps, list relink steps and result handoff
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_handle_pool_macros.svh"

module lhp_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic [lhp_pkg::OP_W-1:0] i_operation,
    output logic                          o_in_stall,
    input  wire logic                     i_out_stall,
    output logic                          o_out_valid,
    output lhp_pkg::t_cmd                 o_cmd,
    input  wire lhp_pkg::t_stat           i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_FIX,
        S_CLEAR,
        S_ADDR,
        S_EVAL,
        S_LINK2,
        S_LINK3,
        S_DONE
    } t_state;

    t_state                   r_state, n_state;
    logic [lhp_pkg::OP_W-1:0] r_op, n_op;
    logic                     r_req, n_req;
    logic                     r_out_valid, n_out_valid;
    lhp_pkg::t_cmd            cmd;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_req   = r_req;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_req = 1'b1;
                    n_op         = i_operation;
                    n_req        = 1'b1;
                    unique case (i_operation)
                        lhp_pkg::OP_INIT: begin
                            cmd.latch_cfg = 1'b1;
                            n_state       = S_INIT;
                        end
                        lhp_pkg::OP_ALLOC, lhp_pkg::OP_TOUCH, lhp_pkg::OP_CHECK: begin
                            n_state = S_ADDR;
                        end
                        lhp_pkg::OP_INVAL: begin
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INIT: begin
                cmd.sweep_init = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                cmd.init_fix = 1'b1;
                n_state      = r_req ? S_DONE : S_IDLE;
            end
            S_CLEAR: begin
                cmd.sweep_clear = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_ADDR: begin
                cmd.rd_issue = 1'b1;
                n_state      = S_EVAL;
            end
            S_EVAL: begin
                if (r_op == lhp_pkg::OP_CHECK) begin
                    cmd.set_match = 1'b1;
                    n_state       = S_DONE;
                end else if (i_stat.slot_ok) begin
                    cmd.link1 = 1'b1;
                    if (r_op == lhp_pkg::OP_ALLOC) begin
                        cmd.wr_owner  = 1'b1;
                        cmd.set_grant = 1'b1;
                    end
                    n_state = S_LINK2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LINK2: begin
                cmd.link2 = 1'b1;
                n_state   = S_LINK3;
            end
            S_LINK3: begin
                cmd.link3 = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_req        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = cmd.out_load | (r_out_valid & i_out_stall);
    end

    // reset starts with the init sweep, with no result owed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_op        <= lhp_pkg::OP_INIT;
            r_req       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_req       <= n_req;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `LHP_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE),
        "accepted request did not start work")
    `LHP_ASSERT_ALWAYS(a_one_mem_step, i_clk,
        $onehot0({cmd.sweep_init, cmd.sweep_clear, cmd.init_fix, cmd.rd_issue,
                  cmd.link1, cmd.link2, cmd.link3}),
        "more than one memory step commanded")

endmodule

`default_nettype wire

### hw/rtl/lhp_dp.sv
// ----------------------------------------------------------------------------
// lhp_dp
// slot memories, list head and tail, sweep counter and result registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_handle_pool_macros.svh"

module lhp_dp #(
    parameter int SLOT_COUNT = 64,
    parameter int OWNER_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lhp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lhp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [lhp_pkg::OP_W-1:0]       i_operation,
    input  wire logic [lhp_pkg::SLOT_W-1:0]     i_slot_index,
    input  wire logic [lhp_pkg::OWNER_W-1:0]    i_owner_id,
    input  wire lhp_pkg::t_cmd                  i_cmd,
    output lhp_pkg::t_stat                      o_stat,
    output logic [lhp_pkg::SLOT_W-1:0]          o_granted_slot,
    output logic                                o_owner_match
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int SW    = lhp_pkg::SLOT_W;

    // memories
    logic [OWNER_BITS-1:0] m_owner [SLOT_COUNT];
    logic [SW-1:0]         m_newer [SLOT_COUNT];
    logic [SW-1:0]         m_older [SLOT_COUNT];
    logic [OWNER_BITS-1:0] r_rd_owner;
    logic [SW-1:0]         r_rd_newer;
    logic [SW-1:0]         r_rd_older;

    // control state
    logic [lhp_pkg::USABLE_W-1:0] r_usable_count;
    logic [SW-1:0]                r_scratch_slot;
    logic [lhp_pkg::USABLE_W-1:0] r_bound;
    logic [SW-1:0]                r_excl;
    logic [SW-1:0]                r_head;
    logic [SW-1:0]                r_tail;
    logic [IDX_W-1:0]             r_cnt;

    // request and result payload
    logic [lhp_pkg::OP_W-1:0]    r_op;
    logic [SW-1:0]               r_idx;
    logic [lhp_pkg::OWNER_W-1:0] r_owner;
    logic [SW-1:0]               r_slot;
    logic [SW-1:0]               r_res_granted;
    logic                        r_res_match;
    logic [SW-1:0]               r_granted_slot;
    logic                        r_owner_match;

    logic                  usable;
    logic [SW-1:0]         sel_slot;
    logic [SW-1:0]         cnt_slot;
    logic                  cnt_free;
    logic [OWNER_BITS-1:0] own_fit;

    logic                  n_we, o_we, w_we;
    logic [IDX_W-1:0]      n_wa, o_wa, w_wa;
    logic [SW-1:0]         n_wd, o_wd;
    logic [OWNER_BITS-1:0] w_wd;

    function automatic logic in_pool(input logic [SW-1:0] s);
        return s < SW'(SLOT_COUNT);
    endfunction

    assign usable   = in_pool(r_idx) && (r_idx < SW'(r_bound)) && (r_idx != r_excl);
    assign sel_slot = usable ? r_idx
                    : ((r_op == lhp_pkg::OP_ALLOC) ? r_tail : lhp_pkg::NONE_SLOT);
    assign cnt_slot = SW'(r_cnt);
    assign cnt_free = (cnt_slot < SW'(r_bound)) && (cnt_slot != r_excl);
    assign own_fit  = OWNER_BITS'(r_owner);

    assign o_stat.slot_ok    = in_pool(r_slot);
    assign o_stat.sweep_last = (r_cnt == IDX_W'(SLOT_COUNT - 1));

    // write port selection, one step at a time
    always_comb begin
        n_we = 1'b0;
        n_wa = '0;
        n_wd = lhp_pkg::NONE_SLOT;
        o_we = 1'b0;
        o_wa = '0;
        o_wd = lhp_pkg::NONE_SLOT;
        w_we = 1'b0;
        w_wa = '0;
        w_wd = '0;
        if (i_cmd.sweep_init) begin
            n_we = 1'b1;
            n_wa = r_cnt;
            n_wd = cnt_free ? r_tail : lhp_pkg::NONE_SLOT;
            if (!cnt_free) begin
                o_we = 1'b1;
                o_wa = r_cnt;
            end else if (in_pool(r_tail)) begin
                o_we = 1'b1;
                o_wa = r_tail[IDX_W-1:0];
                o_wd = cnt_slot;
            end
            w_we = 1'b1;
            w_wa = r_cnt;
        end else if (i_cmd.sweep_clear) begin
            w_we = 1'b1;
            w_wa = r_cnt;
        end else if (i_cmd.init_fix) begin
            // last free slot gets no older neighbor
            o_we = in_pool(r_tail);
            o_wa = r_tail[IDX_W-1:0];
        end else if (i_cmd.link1) begin
            // unlink the slot from its neighbors
            o_we = in_pool(r_rd_newer);
            o_wa = r_rd_newer[IDX_W-1:0];
            o_wd = r_rd_older;
            n_we = in_pool(r_rd_older);
            n_wa = r_rd_older[IDX_W-1:0];
            n_wd = r_rd_newer;
            w_we = i_cmd.wr_owner;
            w_wa = r_slot[IDX_W-1:0];
            w_wd = own_fit;
        end else if (i_cmd.link2) begin
            n_we = 1'b1;
            n_wa = r_slot[IDX_W-1:0];
            o_we = 1'b1;
            o_wa = r_slot[IDX_W-1:0];
            o_wd = r_head;
        end else if (i_cmd.link3) begin
            n_we = in_pool(r_head);
            n_wa = r_head[IDX_W-1:0];
            n_wd = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            m_newer[n_wa] <= n_wd;
        end
        if (o_we) begin
            m_older[o_wa] <= o_wd;
        end
        if (w_we) begin
            m_owner[w_wa] <= w_wd;
        end
        if (i_cmd.rd_issue) begin
            r_rd_newer <= m_newer[sel_slot[IDX_W-1:0]];
            r_rd_older <= m_older[sel_slot[IDX_W-1:0]];
            r_rd_owner <= m_owner[sel_slot[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable_count <= lhp_pkg::USABLE_COUNT_RST;
            r_scratch_slot <= lhp_pkg::SCRATCH_SLOT_RST;
            r_bound        <= lhp_pkg::USABLE_COUNT_RST;
            r_excl         <= lhp_pkg::SCRATCH_SLOT_RST;
            r_head         <= lhp_pkg::NONE_SLOT;
            r_tail         <= lhp_pkg::NONE_SLOT;
            r_cnt          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lhp_pkg::CFG_USABLE_COUNT: begin
                        r_usable_count <= i_cfg_data[lhp_pkg::USABLE_W-1:0];
                    end
                    lhp_pkg::CFG_SCRATCH_SLOT: begin
                        r_scratch_slot <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.latch_cfg) begin
                r_bound <= r_usable_count;
                r_excl  <= r_scratch_slot;
                r_head  <= lhp_pkg::NONE_SLOT;
                r_tail  <= lhp_pkg::NONE_SLOT;
            end
            if (i_cmd.sweep_init || i_cmd.sweep_clear) begin
                r_cnt <= o_stat.sweep_last ? '0 : r_cnt + 1'b1;
            end
            if (i_cmd.sweep_init && cnt_free) begin
                if (!in_pool(r_head)) begin
                    r_head <= cnt_slot;
                end
                r_tail <= cnt_slot;
            end
            if (i_cmd.link1) begin
                if (!in_pool(r_rd_newer)) begin
                    r_head <= r_rd_older;
                end
                if (!in_pool(r_rd_older)) begin
                    r_tail <= r_rd_newer;
                end
            end
            if (i_cmd.link3) begin
                if (!in_pool(r_head)) begin
                    r_tail <= r_slot;
                end
                r_head <= r_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op          <= i_operation;
            r_idx         <= i_slot_index;
            r_owner       <= i_owner_id;
            r_res_granted <= lhp_pkg::NONE_SLOT;
            r_res_match   <= 1'b0;
        end
        if (i_cmd.rd_issue) begin
            r_slot <= sel_slot;
        end
        if (i_cmd.set_grant) begin
            r_res_granted <= r_slot;
        end
        if (i_cmd.set_match) begin
            r_res_match <= usable && (r_rd_owner == own_fit);
        end
        if (i_cmd.out_load) begin
            r_granted_slot <= r_res_granted;
            r_owner_match  <= r_res_match;
        end
    end

    assign o_granted_slot = r_granted_slot;
    assign o_owner_match  = r_owner_match;

    `LHP_ASSERT(a_relink_in_pool, i_clk, i_rst_n,
        (i_cmd.link2 || i_cmd.link3) |-> in_pool(r_slot),
        "relink of a slot outside the pool")
    `LHP_ASSERT(a_slot_at_head, i_clk, i_rst_n,
        i_cmd.link3 |=> (r_head == $past(r_slot)),
        "moved slot is not at the list head")
    `LHP_ASSERT(a_ends_agree, i_clk, i_rst_n,
        i_cmd.out_load |-> (in_pool(r_head) == in_pool(r_tail)),
        "list head and tail disagree on emptiness")

endmodule

`default_nettype wire

### hw/rtl/lru_handle_pool.sv
// a request is taken only in idle; o_in_stall stays high until the previous request
// has handed off its result, so the pool holds one request at a time
// the single-ported link and owner memories allow one list update per cycle
// (no stall can come between the relink steps link1, link2 and link3)
// reset runs an init sweep; o_in_stall stays high after release until the sweep and its fix step are done
// config writes land at once but take effect at the next init
// ----------------------------------------------------------------------------
// lru_handle_pool
// handle slot pool with owner tags, kept in least-recently-used list order
// ----------------------------------------------------------------------------
`default_nettype none

module lru_handle_pool #(
    parameter int SLOT_COUNT = 64,
    parameter int OWNER_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [lhp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lhp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [lhp_pkg::OP_W-1:0]       i_operation,
    input  wire logic [lhp_pkg::SLOT_W-1:0]     i_slot_index,
    input  wire logic [lhp_pkg::OWNER_W-1:0]    i_owner_id,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [lhp_pkg::SLOT_W-1:0]          o_granted_slot,
    output logic                                o_owner_match
);

    // command and status between sequencer and datapath
    lhp_pkg::t_cmd  cmd;
    lhp_pkg::t_stat stat;

    // sequencer: idle accept, sweeps, relink steps, result handoff
    lhp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // datapath: owner and link memories, head and tail, result registers;
    // reserved marks follow from the bound and scratch slot latched at init
    lhp_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .OWNER_BITS (OWNER_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_slot_index   (i_slot_index),
        .i_owner_id     (i_owner_id),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_granted_slot (o_granted_slot),
        .o_owner_match  (o_owner_match)
    );

endmodule

`default_nettype wire
